// File: rtl/wam_pkg.sv
// ----------------------------------------------------------------------------
// Windowed average and maximum: shared definitions
// Widths and reset constants used by the ring, divider and top level.
// ----------------------------------------------------------------------------
package wam_pkg;

  localparam int unsigned Channels      = 4;
  localparam int unsigned SampleW       = 24;
  localparam int unsigned PeakW         = 23;
  localparam int unsigned WinLenW       = 11;
  localparam int unsigned DefMaxWindow  = 1024;
  localparam logic [WinLenW-1:0] WinLenReset = 11'd1000;

  // Record or clear request, carried in the input tuser bit.
  typedef enum logic {
    FUNC_RECORD = 1'b0,
    FUNC_CLEAR  = 1'b1
  } func_t;

endpackage

// File: rtl/wam_ring.sv
// ----------------------------------------------------------------------------
// Sample ring
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wam_ring #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 96
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [DataW-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [DataW-1:0] rd_data
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/wam_div.sv
// ----------------------------------------------------------------------------
// Signed by unsigned divider
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module wam_div
  import wam_pkg::*;
#(
  parameter int unsigned SumW = 35,
  parameter int unsigned CntW = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SumW-1:0]     dividend,
  input  logic [CntW-1:0]     divisor,
  output logic                busy,
  output logic [SampleW-1:0]  quotient
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic              busy_r, busy_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [SumW-1:0]   quo_r, quo_nxt;
  logic [CntW:0]     rem_r, rem_nxt;
  logic [CntW-1:0]   dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [CntW:0]     trial;
  logic [SumW-1:0]   qneg;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    trial    = {rem_r[CntW-1:0], quo_r[SumW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = StepW'(SumW);
      quo_nxt  = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SumW-1];
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[SumW-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg     = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient = qneg[SampleW-1:0];
  assign busy     = busy_r;

endmodule

// File: rtl/windowed_average_and_max.sv
// A record request walks the n newest ring entries, where n is the current window
// count, then divides; the walk reads one ring entry per cycle.
// One request at a time: the serial walk over the ring port and the bit-serial
// dividers finish each record before the next request is accepted.
// A clear request empties the window. Reset (rst_n low, synchronous) empties the
// window and sets the window length to 1000; ring contents are not cleared.
// ----------------------------------------------------------------------------
// Windowed average and maximum
// Keeps the newest samples of four channels in one ring memory and reports,
// per record request, the newest sample, window mean and floored window peak.
// ----------------------------------------------------------------------------
module windowed_average_and_max
  import wam_pkg::*;
#(
  parameter int unsigned MaxWindow = DefMaxWindow
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration: window length, written whenever cfg_wr_en is high.
  input  logic               cfg_wr_en,
  input  logic [WinLenW-1:0] cfg_wr_data,
  // Input request channel.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [95:0]        in_tdata,   // sample_a, sample_b, sample_c, sample_d
  input  logic               in_tuser,   // func
  // Result channel.
  output logic               out_tvalid,
  input  logic               out_tready,
  // latest_a..d, mean_a..d, peak_a..d, then 4 zero bits
  output logic [287:0]       out_tdata
);

  localparam int unsigned AddrW = $clog2(MaxWindow);
  localparam int unsigned CntW  = $clog2(MaxWindow + 1);
  localparam int unsigned SumW  = SampleW + CntW;
  localparam int unsigned RowW  = Channels * SampleW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_DRAIN, ST_DSTART, ST_DIV
  } state_t;

  state_t                  state_r, state_nxt;
  logic [WinLenW-1:0]      wlen_r;
  logic [AddrW-1:0]        wslot_r, wslot_nxt;
  logic [CntW-1:0]         fill_r, fill_nxt;
  logic [AddrW-1:0]        raddr_r, raddr_nxt;
  logic [CntW-1:0]         issued_r, issued_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [RowW-1:0]         latest_r, latest_nxt;
  logic signed [SumW-1:0]  sum_r  [Channels];
  logic signed [SampleW-1:0] peak_r [Channels];
  logic                    out_v_r, out_v_nxt;
  logic [287:0]            out_d_r, out_d_nxt;

  logic                    in_acc, rec_acc, clr_acc, out_free;
  logic [31:0]             eff32;
  logic [CntW-1:0]         eff_len;
  logic [CntW:0]           fill_inc;
  logic [RowW-1:0]         rd_row;
  logic [Channels-1:0]     div_busy;
  logic [SampleW-1:0]      mean   [Channels];
  logic                    div_start;

  // Effective window length: zero reads as one, above the ring depth saturates.
  always_comb begin
    eff32 = 32'(wlen_r);
    if (eff32 == 32'd0) begin
      eff32 = 32'd1;
    end
    if (eff32 > MaxWindow) begin
      eff32 = MaxWindow;
    end
  end
  assign eff_len  = eff32[CntW-1:0];
  assign fill_inc = {1'b0, fill_r} + 1'b1;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rec_acc   = in_acc && (func_t'(in_tuser) == FUNC_RECORD);
  assign clr_acc   = in_acc && (func_t'(in_tuser) == FUNC_CLEAR);
  assign out_free  = !out_v_r || out_tready;
  assign div_start = (state_r == ST_DSTART);

  // The new row is written at the accepting edge, so the walk that starts on
  // the next cycle already reads it back at the write slot.
  wam_ring #(
    .Depth (MaxWindow),
    .AddrW (AddrW),
    .DataW (RowW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (rec_acc),
    .wr_addr (wslot_r),
    .wr_data (in_tdata),
    .rd_addr (raddr_r),
    .rd_data (rd_row)
  );

  for (genvar c = 0; c < Channels; c++) begin : g_div
    wam_div #(
      .SumW (SumW),
      .CntW (CntW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (sum_r[c]),
      .divisor  (fill_r),
      .busy     (div_busy[c]),
      .quotient (mean[c])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    wslot_nxt  = wslot_r;
    fill_nxt   = fill_r;
    raddr_nxt  = raddr_r;
    issued_nxt = issued_r;
    rd_v_nxt   = 1'b0;
    latest_nxt = latest_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_d_nxt  = out_d_r;
    case (state_r)
      ST_IDLE: begin
        if (clr_acc) begin
          wslot_nxt = '0;
          fill_nxt  = '0;
        end else if (rec_acc) begin
          wslot_nxt  = (wslot_r == AddrW'(MaxWindow - 1)) ? '0 : wslot_r + 1'b1;
          fill_nxt   = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[CntW-1:0];
          raddr_nxt  = wslot_r;
          issued_nxt = '0;
          latest_nxt = in_tdata;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        // Walk from the newest entry backward, one read per cycle.
        rd_v_nxt   = 1'b1;
        issued_nxt = issued_r + 1'b1;
        raddr_nxt  = (raddr_r == '0) ? AddrW'(MaxWindow - 1) : raddr_r - 1'b1;
        if (issued_r + 1'b1 == fill_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_busy == '0 && out_free) begin
          out_v_nxt = 1'b1;
          out_d_nxt = '0;
          out_d_nxt[RowW-1:0] = latest_r;
          for (int c = 0; c < Channels; c++) begin
            out_d_nxt[RowW + c*SampleW +: SampleW]   = mean[c];
            out_d_nxt[2*RowW + c*PeakW +: PeakW]     = peak_r[c][PeakW-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wlen_r   <= WinLenReset;
      wslot_r  <= '0;
      fill_r   <= '0;
      rd_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      issued_r <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_wr_en) begin
        wlen_r <= cfg_wr_data;
      end
      wslot_r  <= wslot_nxt;
      fill_r   <= fill_nxt;
      rd_v_r   <= rd_v_nxt;
      out_v_r  <= out_v_nxt;
      issued_r <= issued_nxt;
    end
    raddr_r  <= raddr_nxt;
    latest_r <= latest_nxt;
    out_d_r  <= out_d_nxt;
  end

  // Per-channel accumulation of the sum and the zero-floored peak.
  always_ff @(posedge clk) begin
    for (int c = 0; c < Channels; c++) begin
      if (rec_acc) begin
        sum_r[c]  <= '0;
        peak_r[c] <= '0;
      end else if (rd_v_r) begin
        sum_r[c] <= sum_r[c] + SumW'(signed'(rd_row[c*SampleW +: SampleW]));
        if (signed'(rd_row[c*SampleW +: SampleW]) > peak_r[c]) begin
          peak_r[c] <= signed'(rd_row[c*SampleW +: SampleW]);
        end
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(MaxWindow))
    else $error("window count exceeds ring depth");

  a_rec_walks : assert property (@(posedge clk) disable iff (!rst_n)
    rec_acc |=> (state_r == ST_WALK) && (fill_r != '0))
    else $error("record request did not start a walk");

  a_div_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> (div_busy == '0))
    else $error("result issued while dividers busy");

  a_slot_range : assert property (@(posedge clk) disable iff (!rst_n)
    wslot_r <= AddrW'(MaxWindow - 1))
    else $error("write slot out of range");

endmodule
